// ===== rtl/core/pli_pkg.sv =====
`timescale 1ns / 1ps
// Package with the beat types, codes and cell controls of the positional list.
package pli_pkg;

	localparam int IDX_W = 7;

	typedef enum logic [2:0] {
		OP_INS_FRONT = 3'd0,
		OP_INS_BACK  = 3'd1,
		OP_INS_POS   = 3'd2,
		OP_DEL_BACK  = 3'd3,
		OP_DEL_FRONT = 3'd4,
		OP_DEL_POS   = 3'd5,
		OP_DUMP      = 3'd6,
		OP_BAD       = 3'd7
	} pli_op_e;

	typedef enum logic [2:0] {
		STAT_OK     = 3'd0,
		STAT_FULL   = 3'd1,
		STAT_EMPTY  = 3'd2,
		STAT_BADPOS = 3'd3,
		STAT_BADOP  = 3'd4
	} pli_status_e;

	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_INS,
		CMD_DEL,
		CMD_ROT
	} pli_cmd_e;

	typedef enum logic {
		FSM_IDLE,
		FSM_DUMP
	} pli_fsm_e;

	typedef struct packed {
		logic [2:0]         op;
		logic [4:0]         position;
		logic signed [31:0] value;
	} pli_req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] data;
		logic               last;
		logic [6:0]         count;
	} pli_rsp_t;

	typedef struct packed {
		pli_cmd_e           cmd;
		logic [IDX_W-1:0]   idx;
		logic signed [31:0] value;
	} pli_ctrl_t;

endpackage

// ===== rtl/core/positional_list_insert_delete.sv =====
`timescale 1ns / 1ps
// Top level of the positional list: request decode, dump sequencer and the row of cells.
//
// Usage: requests arrive on the req channel (req_valid, req_stall, req) and
// results leave on the rsp channel (rsp_valid, rsp_stall, rsp). A beat moves
// at a clock edge where valid is high and stall is low.
// Edit requests (inserts, deletes) and failed requests give one result beat,
// registered in the cycle after the request beat. Every cell of the row shifts
// at once, so such requests are taken one per cycle while the receiver keeps
// up. A dump of N entries gives N beats, one per cycle while the receiver
// keeps up, with last on the final one; the list rotates through the head
// cell and is back in order at the end. The request channel is stalled from
// the dump beat until the final dump beat is loaded.
// Reset empties the list at once; no clearing pass is needed because entries
// at and above the count never reach a result beat.
// When the receiver stalls, the result beat holds in the output register and
// the request channel stalls until that register frees up.
module positional_list_insert_delete import pli_pkg::*; #(
	parameter int LIST_DEPTH = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  pli_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output pli_rsp_t rsp
);

	localparam int CNT_W = $clog2(LIST_DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(LIST_DEPTH);

	pli_fsm_e           state_q;
	pli_fsm_e           state_d;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_d;
	logic [CNT_W-1:0]   left_q;
	logic               rsp_valid_q;
	pli_rsp_t           rsp_q;
	pli_rsp_t           rsp_d;
	logic               load_rsp;
	logic               slot_free;
	logic               accept;
	logic               dump_start;
	logic               dump_emit;
	pli_ctrl_t          ctrl;
	logic [IDX_W-1:0]   cnt_ext;
	logic [IDX_W-1:0]   pos_ext;
	logic signed [31:0] entries [LIST_DEPTH];

	assign cnt_ext   = IDX_W'(count_q);
	assign pos_ext   = IDX_W'(req.position);
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != FSM_IDLE) || !slot_free;
	assign accept    = req_valid && !req_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (dump_start) begin
					state_d = FSM_DUMP;
				end
			end
			FSM_DUMP: begin
				if (dump_emit && left_q == CNT_W'(1)) begin
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_comb begin
		load_rsp   = 1'b0;
		dump_start = 1'b0;
		dump_emit  = 1'b0;
		count_d    = count_q;
		ctrl.cmd   = CMD_HOLD;
		ctrl.idx   = '0;
		ctrl.value = req.value;
		rsp_d        = '0;
		rsp_d.status = STAT_OK;
		rsp_d.last   = 1'b1;
		case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					load_rsp = 1'b1;
					case (pli_op_e'(req.op))
						OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
							if (count_q == CNT_MAX) begin
								rsp_d.status = STAT_FULL;
							end else if (req.op == OP_INS_FRONT) begin
								ctrl.cmd = CMD_INS;
								ctrl.idx = '0;
								count_d  = count_q + CNT_W'(1);
							end else if (req.op == OP_INS_BACK) begin
								ctrl.cmd = CMD_INS;
								ctrl.idx = cnt_ext;
								count_d  = count_q + CNT_W'(1);
							end else if (pos_ext == '0 || pos_ext > cnt_ext + IDX_W'(1)) begin
								rsp_d.status = STAT_BADPOS;
							end else begin
								ctrl.cmd = CMD_INS;
								ctrl.idx = pos_ext - IDX_W'(1);
								count_d  = count_q + CNT_W'(1);
							end
						end
						OP_DEL_BACK, OP_DEL_FRONT, OP_DEL_POS: begin
							if (count_q == '0) begin
								rsp_d.status = STAT_EMPTY;
							end else if (req.op == OP_DEL_BACK) begin
								count_d = count_q - CNT_W'(1);
							end else if (req.op == OP_DEL_FRONT) begin
								ctrl.cmd = CMD_DEL;
								ctrl.idx = '0;
								count_d  = count_q - CNT_W'(1);
							end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
								rsp_d.status = STAT_BADPOS;
							end else begin
								ctrl.cmd = CMD_DEL;
								ctrl.idx = pos_ext - IDX_W'(1);
								count_d  = count_q - CNT_W'(1);
							end
						end
						OP_DUMP: begin
							if (count_q == '0) begin
								rsp_d.status = STAT_EMPTY;
							end else begin
								load_rsp   = 1'b0;
								dump_start = 1'b1;
							end
						end
						default: begin
							rsp_d.status = STAT_BADOP;
						end
					endcase
				end
			end
			FSM_DUMP: begin
				if (slot_free) begin
					dump_emit  = 1'b1;
					load_rsp   = 1'b1;
					rsp_d.data = entries[0];
					rsp_d.last = (left_q == CNT_W'(1));
					ctrl.cmd   = CMD_ROT;
					ctrl.idx   = cnt_ext - IDX_W'(1);
				end
			end
			default: begin
				load_rsp = 1'b0;
			end
		endcase
		rsp_d.count = 7'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			count_q     <= '0;
			left_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (dump_start) begin
				left_q <= count_q;
			end else if (dump_emit) begin
				left_q <= left_q - CNT_W'(1);
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
		logic signed [31:0] lower;
		logic signed [31:0] upper;
		if (i == 0) begin : g_first
			assign lower = entries[i];
		end else begin : g_inner_lo
			assign lower = entries[i-1];
		end
		if (i == LIST_DEPTH - 1) begin : g_last
			assign upper = entries[i];
		end else begin : g_inner_hi
			assign upper = entries[i+1];
		end
		pli_cell #(
			.INDEX(i)
		) u_cell (
			.clk   (clk),
			.ctrl  (ctrl),
			.lower (lower),
			.upper (upper),
			.head  (entries[0]),
			.entry (entries[i])
		);
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("entry count exceeds list depth");

	a_dump_left: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FSM_DUMP |-> (left_q != '0 && left_q <= count_q))
		else $error("dump counter out of range");

	a_dump_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FSM_DUMP |-> req_stall)
		else $error("request taken during dump");

	a_partial_dump: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_q.last) |-> state_q == FSM_DUMP)
		else $error("non-final beat outside a dump");

endmodule

// ===== rtl/core/pli_cell.sv =====
`timescale 1ns / 1ps
// One list cell: holds an entry and takes a new value, a neighbor's value or the head.
module pli_cell import pli_pkg::*; #(
	parameter int INDEX = 0
) (
	input  logic               clk,
	input  pli_ctrl_t          ctrl,
	input  logic signed [31:0] lower,
	input  logic signed [31:0] upper,
	input  logic signed [31:0] head,
	output logic signed [31:0] entry
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	logic signed [31:0] entry_q;
	logic signed [31:0] entry_d;

	always_comb begin
		entry_d = entry_q;
		case (ctrl.cmd)
			CMD_INS: begin
				if (MY_IDX > ctrl.idx) begin
					entry_d = lower;
				end else if (MY_IDX == ctrl.idx) begin
					entry_d = ctrl.value;
				end
			end
			CMD_DEL: begin
				if (MY_IDX >= ctrl.idx) begin
					entry_d = upper;
				end
			end
			CMD_ROT: begin
				if (MY_IDX == ctrl.idx) begin
					entry_d = head;
				end else if (MY_IDX < ctrl.idx) begin
					entry_d = upper;
				end
			end
			default: begin
				entry_d = entry_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign entry = entry_q;

endmodule

// ===== test/list_checker.sv =====
`timescale 1ns / 1ps
// Checker that predicts the result beats of the positional list and compares them.
module list_checker import pli_pkg::*; #(
	parameter int LIST_DEPTH = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  logic     req_stall,
	input  pli_req_t req,
	input  logic     rsp_valid,
	input  logic     rsp_stall,
	input  pli_rsp_t rsp,
	output int       fail_count,
	output int       pending,
	output int       stored_count
);

	logic signed [31:0] entries [LIST_DEPTH];
	int entry_count;
	pli_rsp_t due_beats [$];

	task automatic push_beat(input pli_status_e st, input logic signed [31:0] data,
		input logic last);
		pli_rsp_t beat;
		beat.status = st;
		beat.data = data;
		beat.last = last;
		beat.count = entry_count[6:0];
		due_beats.push_back(beat);
	endtask

	task automatic apply_request(input pli_req_t r);
		pli_status_e st;
		int idx;
		int i;
		st = STAT_OK;
		idx = 0;
		case (r.op)
		OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
			if (entry_count >= LIST_DEPTH) begin
				st = STAT_FULL;
			end else if (r.op == OP_INS_FRONT) begin
				idx = 0;
			end else if (r.op == OP_INS_BACK) begin
				idx = entry_count;
			end else if (r.position < 1 || r.position > entry_count + 1) begin
				st = STAT_BADPOS;
			end else begin
				idx = r.position - 1;
			end
			if (st == STAT_OK) begin
				for (i = entry_count; i > idx; i--)
					entries[i] = entries[i - 1];
				entries[idx] = r.value;
				entry_count++;
			end
		end
		OP_DEL_BACK, OP_DEL_FRONT, OP_DEL_POS: begin
			if (entry_count == 0) begin
				st = STAT_EMPTY;
			end else if (r.op == OP_DEL_BACK) begin
				idx = entry_count - 1;
			end else if (r.op == OP_DEL_FRONT) begin
				idx = 0;
			end else if (r.position < 1 || r.position > entry_count) begin
				st = STAT_BADPOS;
			end else begin
				idx = r.position - 1;
			end
			if (st == STAT_OK) begin
				for (i = idx; i + 1 < entry_count; i++)
					entries[i] = entries[i + 1];
				entry_count--;
			end
		end
		OP_DUMP: begin
			if (entry_count == 0) begin
				st = STAT_EMPTY;
			end else begin
				for (i = 0; i < entry_count; i++)
					push_beat(STAT_OK, entries[i], i + 1 == entry_count);
				return;
			end
		end
		default: begin
			st = STAT_BADOP;
		end
		endcase
		push_beat(st, '0, 1'b1);
	endtask

	task automatic compare_beat(input pli_rsp_t got);
		pli_rsp_t want;
		if (due_beats.size() == 0) begin
			$display("%0t: unexpected result beat: status %0d data %0d last %0d count %0d",
				$time, got.status, got.data, got.last, got.count);
			fail_count++;
		end else begin
			want = due_beats.pop_front();
			if (got.status !== want.status || got.data !== want.data ||
				got.last !== want.last || got.count !== want.count) begin
				$display("%0t: mismatch, expected status %0d data %0d last %0d count %0d",
					$time, want.status, want.data, want.last, want.count);
				$display("%0t:           actual status %0d data %0d last %0d count %0d",
					$time, got.status, got.data, got.last, got.count);
				fail_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count = 0;
			due_beats.delete();
			fail_count = 0;
			pending = 0;
			stored_count = 0;
		end else begin
			if (req_valid && !req_stall)
				apply_request(req);
			if (rsp_valid && !rsp_stall)
				compare_beat(rsp);
			pending = due_beats.size();
			stored_count = entry_count;
		end
	end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Top of the positional list testbench: clock, reset, request and stall stimulus, verdict.
module testbench;
	import pli_pkg::*;

	localparam int LIST_DEPTH = 16;
	localparam int QUIET_LIMIT = 1000;
	localparam int RANDOM_ITEMS = 450;

	logic     clk;
	logic     arst_n;
	logic     req_valid;
	logic     req_stall;
	pli_req_t req;
	logic     rsp_valid;
	logic     rsp_stall;
	pli_rsp_t rsp;
	int       fail_count;
	int       pending;
	int       stored_count;
	int       quiet_cycles;

	positional_list_insert_delete #(.LIST_DEPTH(LIST_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	list_checker #(.LIST_DEPTH(LIST_DEPTH)) list_check (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.fail_count(fail_count),
		.pending(pending),
		.stored_count(stored_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int run_len;
		int hold_len;
		rsp_stall = 1'b0;
		forever begin
			run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(0, 12);
			hold_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
				: $urandom_range(1, 3);
			repeat (run_len) @(negedge clk) rsp_stall <= 1'b0;
			repeat (hold_len) @(negedge clk) rsp_stall <= 1'b1;
		end
	end

	// Called at a falling edge; returns right after the edge that takes the beat.
	task automatic put_item(input pli_req_t item);
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic send_fixed(input pli_op_e op, input logic [4:0] pos,
		input logic signed [31:0] val);
		pli_req_t item;
		item.op = op;
		item.position = pos;
		item.value = val;
		@(negedge clk);
		put_item(item);
	endtask

	task automatic hold_off(input int cycles);
		@(negedge clk) req_valid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic random_gap(input bit no_gaps);
		int roll;
		roll = $urandom_range(0, 99);
		if (!no_gaps) begin
			if (roll < 3)
				hold_off($urandom_range(10, 30));
			else if (roll < 30)
				hold_off($urandom_range(1, 3));
		end
	endtask

	task automatic wait_drained();
		@(negedge clk) req_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// Bias 0 favors inserts, 1 is even, 2 favors deletes.
	task automatic send_random(input int bias);
		pli_req_t item;
		int roll;
		int ins_share;
		@(negedge clk);
		roll = $urandom_range(0, 99);
		ins_share = (bias == 0) ? 80 : (bias == 1) ? 50 : 20;
		if (roll < 6)
			item.op = OP_DUMP;
		else if (roll < 9)
			item.op = OP_BAD;
		else if ($urandom_range(0, 99) < ins_share)
			item.op = ($urandom_range(0, 2) == 0) ? OP_INS_FRONT
				: ($urandom_range(0, 1) == 0) ? OP_INS_BACK : OP_INS_POS;
		else
			item.op = ($urandom_range(0, 2) == 0) ? OP_DEL_FRONT
				: ($urandom_range(0, 1) == 0) ? OP_DEL_BACK : OP_DEL_POS;
		if ($urandom_range(0, 4) == 0)
			item.position = 5'($urandom_range(0, 31));
		else if (item.op == OP_INS_POS)
			item.position = 5'($urandom_range(1, stored_count + 1));
		else
			item.position = 5'($urandom_range(1, (stored_count > 0) ? stored_count : 1));
		roll = $urandom_range(0, 9);
		item.value = (roll == 0) ? 32'h8000_0000 : (roll == 1) ? 32'h7fff_ffff
			: $urandom;
		put_item(item);
	endtask

	initial begin
		int sent;
		int bias;
		int phase_len;
		bit no_gaps;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Directed part: failures on an empty list, extreme values and positions.
		send_fixed(OP_BAD, 5'd0, 32'sd0);
		send_fixed(OP_DUMP, 5'd0, 32'sd0);
		send_fixed(OP_DEL_BACK, 5'd0, 32'sd0);
		send_fixed(OP_DEL_FRONT, 5'd0, 32'sd0);
		send_fixed(OP_DEL_POS, 5'd31, 32'sd0);
		random_gap(1'b0);
		send_fixed(OP_INS_POS, 5'd0, 32'sd1);
		send_fixed(OP_INS_POS, 5'd2, 32'sd2);
		send_fixed(OP_INS_POS, 5'd1, 32'sh8000_0000);
		send_fixed(OP_INS_FRONT, 5'd0, 32'sh7fff_ffff);
		send_fixed(OP_INS_BACK, 5'd0, -32'sd1);
		send_fixed(OP_INS_POS, 5'd4, 32'sd0);
		random_gap(1'b0);
		send_fixed(OP_INS_POS, 5'd2, 32'sh5555_5555);
		send_fixed(OP_DUMP, 5'd0, 32'sd0);
		send_fixed(OP_DEL_POS, 5'd0, 32'sd0);
		send_fixed(OP_DEL_POS, 5'd6, 32'sd0);
		send_fixed(OP_DEL_POS, 5'd31, 32'sd0);
		send_fixed(OP_INS_POS, 5'd31, 32'sd3);
		send_fixed(OP_DEL_POS, 5'd5, 32'sd0);
		send_fixed(OP_DEL_POS, 5'd2, 32'sd0);
		send_fixed(OP_DEL_FRONT, 5'd0, 32'sd0);
		send_fixed(OP_DEL_BACK, 5'd0, 32'sd0);
		send_fixed(OP_DUMP, 5'd0, 32'sd0);
		send_fixed(OP_BAD, 5'd31, -32'sd1);
		wait_drained();

		// Random part in phases that push the list toward full, empty or neither.
		sent = 0;
		bias = 0;
		phase_len = 50;
		while (sent < RANDOM_ITEMS) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			repeat (phase_len) begin
				send_random(bias);
				random_gap(no_gaps);
				sent++;
			end
			if ($urandom_range(0, 2) == 0)
				wait_drained();
			bias = $urandom_range(0, 2);
			phase_len = $urandom_range(20, 60);
		end

		wait_drained();
		repeat (20) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/pli_pkg.sv
rtl/core/pli_cell.sv
rtl/core/positional_list_insert_delete.sv
test/list_checker.sv
test/testbench.sv
